// ----- sv/etcc_pkg.sv -----
// Package with the word types, codes and constants of the traffic class counter.
`default_nettype none

package etcc_pkg;

  localparam int unsigned MaxFrameBytes = 1518;
  localparam int unsigned PosW = $clog2(MaxFrameBytes + 1);
  localparam int unsigned PayW = PosW + 8;

  localparam int unsigned NumCounters = 9;
  localparam int unsigned CntW = 32;
  localparam logic [3:0] IDX_TOTAL = 4'd7;
  localparam logic [3:0] IDX_PAYLOAD = 4'd8;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [2:0] CLS_TCP = 3'd0;
  localparam logic [2:0] CLS_UDP = 3'd1;
  localparam logic [2:0] CLS_ICMP = 3'd2;
  localparam logic [2:0] CLS_IGMP = 3'd3;
  localparam logic [2:0] CLS_OSPF = 3'd4;
  localparam logic [2:0] CLS_ARP = 3'd5;
  localparam logic [2:0] CLS_OTHER = 3'd6;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_OSPF = 8'd89;
  localparam logic [3:0] IP_VERSION_4 = 4'd4;
  localparam logic [7:0] ETH_HDR_BYTES = 8'd14;
  localparam logic [7:0] UDP_HDR_BYTES = 8'd8;
  localparam logic [7:0] TCP_OFFSET_BASE = 8'd26;

  localparam logic CFG_TCP_ENABLE = 1'b0;
  localparam logic CFG_UDP_ENABLE = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic [3:0] counter_select;
  } etcc_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  traffic_class;
    logic [10:0] frame_bytes;
    logic        length_mismatch;
    logic [31:0] counter_value;
  } etcc_out_t;

endpackage

`default_nettype wire

// ----- sv/ethernet_traffic_class_counter_unit.sv -----
// Top level of the Ethernet traffic class byte counter with its read port.
//
// Channel | Direction | Handshake                  | Word
// in      | input     | in_valid_i / in_stall_o    | etcc_in_t
// out     | output    | out_valid_o / out_stall_i  | etcc_out_t
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One word is accepted every cycle unless the input stalls; header fields are captured as each byte arrives.
// A frame summary or read answer passes through the summary register, then the output register.
// The rate is set by the summary register feeding the counter lanes and output register.
// Reset clears the counters, the enables and the frame capture state at once.
// A stalled output holds its word; the input stalls only when both registers are full.
`default_nettype none

module ethernet_traffic_class_counter_unit import etcc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire etcc_in_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output etcc_out_t      out_word_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic      cfg_index_i,
  input  wire logic      cfg_data_i
);

  typedef struct packed {
    logic            is_read;
    logic [3:0]      sel;
    logic [PosW-1:0] n;
    logic [15:0]     etype;
    logic [3:0]      version;
    logic [3:0]      ihl;
    logic [15:0]     total_len;
    logic [7:0]      proto;
    logic [3:0]      tcp_words;
  } etcc_stage_t;

  logic            tcp_en_q, udp_en_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     etype_q, etype_d;
  logic [3:0]      version_q, version_d;
  logic [3:0]      ihl_q, ihl_d;
  logic [15:0]     total_q, total_d;
  logic [7:0]      proto_q, proto_d;
  logic [3:0]      tcpw_q, tcpw_d;

  logic            s1_valid_q, s1_valid_d;
  etcc_stage_t     s1_q, s1_d;
  logic            s1_fire;
  logic            out_valid_q, out_valid_d;
  etcc_out_t       out_q, out_d;

  logic [CntW-1:0] cnt_q [NumCounters];
  logic [CntW-1:0] cnt_d [NumCounters];
  logic [CntW-1:0] amt [NumCounters];

  logic            in_fire;
  logic            loads_stage;
  logic [7:0]      tcp_pos;

  logic            ipv4;
  logic [2:0]      cls;
  logic            mismatch;
  logic            pay_en;
  logic [7:0]      hlen;
  logic [7:0]      hdr_sum;
  logic [PayW-1:0] pay;
  logic [CntW:0]   sum;

  assign cfg_ready_o = 1'b1;

  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign tcp_pos    = TCP_OFFSET_BASE + {2'b00, ihl_q, 2'b00};

  always_comb begin
    pos_d       = pos_q;
    etype_d     = etype_q;
    version_d   = version_q;
    ihl_d       = ihl_q;
    total_d     = total_q;
    proto_d     = proto_q;
    tcpw_d      = tcpw_q;
    loads_stage = 1'b0;
    s1_d        = s1_q;
    if (in_fire) begin
      if (in_word_i.opcode == OP_READ) begin
        loads_stage    = 1'b1;
        s1_d           = '0;
        s1_d.is_read   = 1'b1;
        s1_d.sel       = in_word_i.counter_select;
      end else begin
        if (PayW'(pos_q) < PayW'(MaxFrameBytes)) begin
          if (PayW'(pos_q) == PayW'(12) || PayW'(pos_q) == PayW'(13)) begin
            etype_d = {etype_q[7:0], in_word_i.frame_byte};
          end
          if (PayW'(pos_q) == PayW'(14)) begin
            version_d = in_word_i.frame_byte[7:4];
            ihl_d     = in_word_i.frame_byte[3:0];
          end
          if (PayW'(pos_q) == PayW'(16) || PayW'(pos_q) == PayW'(17)) begin
            total_d = {total_q[7:0], in_word_i.frame_byte};
          end
          if (PayW'(pos_q) == PayW'(23)) begin
            proto_d = in_word_i.frame_byte;
          end
          if (PayW'(pos_q) == PayW'(tcp_pos)) begin
            tcpw_d = in_word_i.frame_byte[7:4];
          end
          pos_d = pos_q + PosW'(1);
        end
        if (in_word_i.frame_end) begin
          loads_stage    = 1'b1;
          s1_d.is_read   = 1'b0;
          s1_d.sel       = in_word_i.counter_select;
          s1_d.n         = pos_d;
          s1_d.etype     = etype_d;
          s1_d.version   = version_d;
          s1_d.ihl       = ihl_d;
          s1_d.total_len = total_d;
          s1_d.proto     = proto_d;
          s1_d.tcp_words = tcpw_d;
          pos_d     = '0;
          etype_d   = '0;
          version_d = '0;
          ihl_d     = '0;
          total_d   = '0;
          proto_d   = '0;
          tcpw_d    = '0;
        end
      end
    end
    s1_valid_d = loads_stage || (s1_valid_q && !s1_fire);
  end

  always_comb begin
    ipv4 = (s1_q.etype == ETYPE_IPV4) && (s1_q.version == IP_VERSION_4);
    cls  = CLS_OTHER;
    if (ipv4) begin
      case (s1_q.proto)
        PROTO_TCP:  cls = CLS_TCP;
        PROTO_UDP:  cls = CLS_UDP;
        PROTO_ICMP: cls = CLS_ICMP;
        PROTO_IGMP: cls = CLS_IGMP;
        PROTO_OSPF: cls = CLS_OSPF;
        default:    cls = CLS_OTHER;
      endcase
    end else if (s1_q.etype == ETYPE_ARP) begin
      cls = CLS_ARP;
    end
    mismatch = ipv4 && (17'(s1_q.n) != ({1'b0, s1_q.total_len} + 17'(ETH_HDR_BYTES)));
    pay_en   = 1'b0;
    hlen     = '0;
    if (ipv4 && cls == CLS_TCP && tcp_en_q) begin
      pay_en = 1'b1;
      hlen   = {2'b00, s1_q.tcp_words, 2'b00};
    end else if (ipv4 && cls == CLS_UDP && udp_en_q) begin
      pay_en = 1'b1;
      hlen   = UDP_HDR_BYTES;
    end
    hdr_sum = ETH_HDR_BYTES + {2'b00, s1_q.ihl, 2'b00} + hlen;
    pay = (PayW'(s1_q.n) >= PayW'(hdr_sum)) ? (PayW'(s1_q.n) - PayW'(hdr_sum)) : '0;
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NumCounters; i++) begin
      amt[i] = '0;
      if (s1_fire && !s1_q.is_read) begin
        if (i < 7 && cls == 3'(i)) begin
          amt[i] = CntW'(s1_q.n);
        end
        if (4'(i) == IDX_TOTAL) begin
          amt[i] = CntW'(s1_q.n);
        end
        if (4'(i) == IDX_PAYLOAD && pay_en) begin
          amt[i] = CntW'(pay);
        end
      end
      sum      = {1'b0, cnt_q[i]} + {1'b0, amt[i]};
      cnt_d[i] = sum[CntW] ? '1 : sum[CntW-1:0];
    end
  end

  always_comb begin
    out_d = out_q;
    if (s1_fire) begin
      out_d = '0;
      if (s1_q.is_read) begin
        out_d.result_kind = KIND_READ;
        if (s1_q.sel < 4'(NumCounters)) begin
          out_d.counter_value = cnt_q[s1_q.sel];
        end
      end else begin
        out_d.result_kind     = KIND_SUMMARY;
        out_d.traffic_class   = cls;
        out_d.frame_bytes     = 11'(s1_q.n);
        out_d.length_mismatch = mismatch;
      end
    end
    out_valid_d = s1_fire || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcp_en_q    <= 1'b0;
      udp_en_q    <= 1'b0;
      pos_q       <= '0;
      etype_q     <= '0;
      version_q   <= '0;
      ihl_q       <= '0;
      total_q     <= '0;
      proto_q     <= '0;
      tcpw_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_TCP_ENABLE) begin
          tcp_en_q <= cfg_data_i;
        end
        if (cfg_index_i == CFG_UDP_ENABLE) begin
          udp_en_q <= cfg_data_i;
        end
      end
      pos_q       <= pos_d;
      etype_q     <= etype_d;
      version_q   <= version_d;
      ihl_q       <= ihl_d;
      total_q     <= total_d;
      proto_q     <= proto_d;
      tcpw_q      <= tcpw_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while the pipeline could advance");

  a_position_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PayW'(pos_q) <= PayW'(MaxFrameBytes))
    else $error("byte position ran past the maximum frame length");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q[IDX_TOTAL] >= $past(cnt_q[IDX_TOTAL]))
    else $error("total byte counter decreased");

  a_mismatch_ipv4_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.result_kind == KIND_SUMMARY && out_word_o.length_mismatch)
      |-> (out_word_o.traffic_class != CLS_ARP))
    else $error("length mismatch flagged on an ARP frame");

endmodule

`default_nettype wire

// ----- bench/tb_ethernet_traffic_class_counter_unit.sv -----
// Self-checking testbench for the Ethernet traffic class byte counter unit.
module tb_ethernet_traffic_class_counter_unit import etcc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles = 300;
  localparam int PhaseWords = 110;
  localparam int PhaseFrames = 2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  etcc_in_t in_word = '0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall = 1'b0;
  etcc_out_t out_word_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic cfg_index = CFG_TCP_ENABLE;
  logic cfg_data = 1'b0;

  etcc_in_t pending_words[$];
  etcc_out_t expected_results[$];
  int words_queued = 0;
  int words_accepted = 0;
  int phase_words = 0;
  bit word_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int errors = 0;

  // Shadow of the frame capture state, the enables and the counters.
  int frame_pos = 0;
  logic [15:0] cap_etype = '0;
  logic [3:0] cap_version = '0;
  logic [3:0] cap_ihl = '0;
  logic [15:0] cap_total_len = '0;
  logic [7:0] cap_proto = '0;
  logic [3:0] cap_tcp_off = '0;
  logic [CntW-1:0] byte_count[NumCounters];
  logic tcp_pay_en = 1'b0;
  logic udp_pay_en = 1'b0;

  ethernet_traffic_class_counter_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < NumCounters; i++) begin
      byte_count[i] = '0;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic logic [CntW-1:0] sat_sum(input logic [CntW-1:0] a, input int b);
    logic [CntW:0] s;
    s = {1'b0, a} + CntW'(b);
    return s[CntW] ? '1 : s[CntW-1:0];
  endfunction

  task automatic clear_capture();
    frame_pos = 0;
    cap_etype = '0;
    cap_version = '0;
    cap_ihl = '0;
    cap_total_len = '0;
    cap_proto = '0;
    cap_tcp_off = '0;
  endtask

  task automatic classify_and_count(input etcc_in_t w);
    etcc_out_t r;
    int n;
    int hdr;
    int pay;
    logic [2:0] cls;
    r = '0;
    if (w.opcode == OP_READ) begin
      r.result_kind = KIND_READ;
      r.counter_value = (w.counter_select < NumCounters) ? byte_count[w.counter_select] : '0;
      expected_results.push_back(r);
    end else begin
      if (frame_pos < MaxFrameBytes) begin
        if (frame_pos == 12 || frame_pos == 13) cap_etype = {cap_etype[7:0], w.frame_byte};
        if (frame_pos == 14) {cap_version, cap_ihl} = w.frame_byte;
        if (frame_pos == 16 || frame_pos == 17) begin
          cap_total_len = {cap_total_len[7:0], w.frame_byte};
        end
        if (frame_pos == 23) cap_proto = w.frame_byte;
        if (frame_pos == int'(TCP_OFFSET_BASE) + 4 * int'(cap_ihl)) begin
          cap_tcp_off = w.frame_byte[7:4];
        end
        frame_pos++;
      end
      if (w.frame_end) begin
        n = frame_pos;
        cls = CLS_OTHER;
        r.result_kind = KIND_SUMMARY;
        if (cap_etype == ETYPE_IPV4 && cap_version == IP_VERSION_4) begin
          case (cap_proto)
            PROTO_TCP: cls = CLS_TCP;
            PROTO_UDP: cls = CLS_UDP;
            PROTO_ICMP: cls = CLS_ICMP;
            PROTO_IGMP: cls = CLS_IGMP;
            PROTO_OSPF: cls = CLS_OSPF;
            default: cls = CLS_OTHER;
          endcase
          r.length_mismatch = (n != int'(cap_total_len) + int'(ETH_HDR_BYTES));
          hdr = -1;
          if (cls == CLS_TCP && tcp_pay_en) hdr = 4 * int'(cap_tcp_off);
          else if (cls == CLS_UDP && udp_pay_en) hdr = int'(UDP_HDR_BYTES);
          if (hdr >= 0) begin
            pay = n - int'(ETH_HDR_BYTES) - 4 * int'(cap_ihl) - hdr;
            if (pay < 0) pay = 0;
            byte_count[IDX_PAYLOAD] = sat_sum(byte_count[IDX_PAYLOAD], pay);
          end
        end else if (cap_etype == ETYPE_ARP) begin
          cls = CLS_ARP;
        end
        byte_count[{1'b0, cls}] = sat_sum(byte_count[{1'b0, cls}], n);
        byte_count[IDX_TOTAL] = sat_sum(byte_count[IDX_TOTAL], n);
        r.traffic_class = cls;
        r.frame_bytes = n[10:0];
        expected_results.push_back(r);
        clear_capture();
      end
    end
  endtask

  always @(posedge clk_i) begin
    word_taken = 1'b0;
    if (rst_ni && in_valid && !in_stall_o) begin
      classify_and_count(in_word);
      words_accepted++;
      word_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid || word_taken) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_word <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_left = HoldCycles;
      hold_served++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : result_check
    etcc_out_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", 32'(out_word_o.result_kind), 32'(want.result_kind));
        check_field("traffic_class", 32'(out_word_o.traffic_class),
                    32'(want.traffic_class));
        check_field("frame_bytes", 32'(out_word_o.frame_bytes), 32'(want.frame_bytes));
        check_field("length_mismatch", 32'(out_word_o.length_mismatch),
                    32'(want.length_mismatch));
        check_field("counter_value", out_word_o.counter_value, want.counter_value);
      end
    end
  end

  task automatic push_word(input etcc_in_t w);
    pending_words.push_back(w);
    words_queued++;
    phase_words++;
  endtask

  task automatic push_read(input logic [3:0] sel);
    etcc_in_t w;
    w.opcode = OP_READ;
    w.frame_byte = 8'($urandom_range(255));
    w.frame_end = 1'($urandom_range(1));
    w.counter_select = sel;
    push_word(w);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    etcc_in_t w;
    w.opcode = OP_DATA;
    w.frame_byte = b;
    w.frame_end = last;
    w.counter_select = 4'($urandom_range(15));
    push_word(w);
  endtask

  function automatic int pick_frame_len();
    int r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(1, 46);
    if (r < 85) return $urandom_range(47, 90);
    return $urandom_range(91, 160);
  endfunction

  function automatic logic [7:0] pick_protocol();
    int r;
    r = $urandom_range(99);
    if (r < 35) return PROTO_TCP;
    if (r < 65) return PROTO_UDP;
    if (r < 73) return PROTO_ICMP;
    if (r < 81) return PROTO_IGMP;
    if (r < 89) return PROTO_OSPF;
    return 8'($urandom_range(255));
  endfunction

  // Noise frames are random bytes; the rest carry plausible headers with random content.
  task automatic send_frame(input int len, input bit noise);
    logic [15:0] etype;
    logic [15:0] tot;
    logic [3:0] ver;
    logic [3:0] ihl;
    logic [3:0] toff;
    logic [7:0] proto;
    logic [7:0] b;
    int r;
    r = $urandom_range(99);
    etype = (r < 70) ? ETYPE_IPV4 : (r < 85) ? ETYPE_ARP : 16'($urandom_range(16'hFFFF));
    ver = ($urandom_range(99) < 85) ? IP_VERSION_4 : 4'($urandom_range(15));
    ihl = ($urandom_range(99) < 75) ? 4'd5 : 4'($urandom_range(15));
    toff = ($urandom_range(99) < 75) ? 4'd5 : 4'($urandom_range(15));
    proto = pick_protocol();
    tot = ($urandom_range(99) < 70) ? 16'(len - int'(ETH_HDR_BYTES)) :
          16'($urandom_range(16'hFFFF));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (!noise) begin
        if (i == 12) b = etype[15:8];
        if (i == 13) b = etype[7:0];
        if (i == 14) b = {ver, ihl};
        if (i == 16) b = tot[15:8];
        if (i == 17) b = tot[7:0];
        if (i == 23) b = proto;
        if (i == int'(TCP_OFFSET_BASE) + 4 * int'(ihl)) b = {toff, b[3:0]};
      end
      if ($urandom_range(99) < 8) push_read(4'($urandom_range(15)));
      push_byte(b, i == len - 1);
    end
    if ($urandom_range(99) < 25) push_read(4'($urandom_range(15)));
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (words_accepted != words_queued || expected_results.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_config(input logic idx, input logic val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == CFG_TCP_ENABLE) tcp_pay_en = val;
    else udp_pay_en = val;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int send_pct, input int stall_pct, input logic tcp_en,
                           input logic udp_en, input bit long_hold, input bit read_all);
    int frames;
    write_config(CFG_TCP_ENABLE, tcp_en);
    write_config(CFG_UDP_ENABLE, udp_en);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    phase_words = 0;
    frames = 0;
    while (phase_words < PhaseWords || frames < PhaseFrames) begin
      if ($urandom_range(99) < 10) send_frame($urandom_range(1, 40), 1'b1);
      else send_frame(pick_frame_len(), 1'b0);
      frames++;
    end
    if (long_hold) hold_requests++;
    if (read_all) begin
      for (int s = 0; s < 16; s++) push_read(4'(s));
    end
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_config(CFG_TCP_ENABLE, 1'b1);
    write_config(CFG_UDP_ENABLE, 1'b1);

    push_read(4'd0);
    push_read(4'd15);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    for (int i = 0; i < 14; i++) begin
      if (i == 7) push_read({1'b0, CLS_ARP});
      push_byte(i == 12 ? ETYPE_ARP[15:8] : i == 13 ? ETYPE_ARP[7:0] : 8'hFF, i == 13);
    end
    push_read(IDX_TOTAL);
    wait_idle();

    run_phase(58, 0, 1'b1, 1'b0, 1'b0, 1'b0);
    run_phase(0, 58, 1'b0, 1'b1, 1'b1, 1'b0);
    run_phase(13, 13, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(0, 0, 1'b1, 1'b1, 1'b0, 1'b1);

    if (errors == 0) begin
      $display("PASS ethernet_traffic_class_counter_unit");
    end else begin
      $display("FAIL ethernet_traffic_class_counter_unit");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL ethernet_traffic_class_counter_unit");
    $finish;
  end

endmodule
